[design/nearest_group_member_select_unit_defines.svh]
// assertion macros for the nearest group member select unit
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef NEAREST_GROUP_MEMBER_SELECT_UNIT_DEFINES_SVH
`define NEAREST_GROUP_MEMBER_SELECT_UNIT_DEFINES_SVH

// same-cycle implication
`define NGMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NGMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/ngms_pkg.sv]
// shared constants for the nearest group member select unit
// no dependencies
package ngms_pkg;
    localparam int NUM_NODES  = 32;
    localparam int DIST_W     = 16;
    localparam int NODE_W     = $clog2(NUM_NODES);
    localparam int ADDR_W     = 2 * NODE_W;
    localparam int RES_MAX    = NUM_NODES - 1;
    localparam int CNT_W      = $clog2(NUM_NODES + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [NODE_W-1:0] SPLIT_RESET = NODE_W'(14);
endpackage

[design/nearest_group_member_select_unit.sv]
// Nearest group member select unit. Keeps a symmetric node distance table
// in one synchronous memory and answers ranked nearest-neighbor queries.
// Channels: command input (start/busy). A transaction is taken when start
// is high and busy is low. opcode write stores distance_value for the pair
// node_a/node_b in both directions; opcode query names an origin, a count
// and a group (inner: nodes below group_split, outer: the rest).
// Results: one per selected node on o_near_node/o_rank/o_last, each valid
// for one cycle with o_strobe; the receiver cannot stall, results are
// never held back. Results come in ascending distance, ties to lower index.
// Config: i_cfg_valid/o_cfg_ready/i_cfg_data writes group_split while idle.
// Operation: a write stores its two entries one after the other through
// the one memory write port. A query reads one row of 32 entries, one per
// cycle through the registered memory read port, while a sorted cell row
// inserts each candidate, then emits its n results one per cycle. A query
// with no result leaves the block idle. Reset restores group_split to 14
// and idles the block; the distance table is not cleared and holds nothing
// until written.
`include "nearest_group_member_select_unit_defines.svh"

module nearest_group_member_select_unit import ngms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [15:0]       i_distance_value,
    input  logic [NODE_W-1:0] i_wanted_count,
    input  logic              i_inner_group,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [NODE_W-1:0] i_cfg_data,
    output logic              o_strobe,
    output logic [NODE_W-1:0] o_near_node,
    output logic [NODE_W-1:0] o_rank,
    output logic              o_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WR2   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [NODE_W-1:0] LAST_COL = NODE_W'(NUM_NODES - 1);

    logic [2:0]        r_state, n_state;
    logic [NODE_W-1:0] r_split;
    logic [NODE_W-1:0] r_a, r_b;
    logic [DIST_W-1:0] r_dv;
    logic              r_inner;
    logic [NODE_W-1:0] r_n;
    logic [NODE_W-1:0] r_k;
    logic [NODE_W-1:0] r_col;
    logic [NODE_W-1:0] r_rd_col;
    logic              r_rd_vld;
    logic [DIST_W-1:0] r_rd_data;

    logic [DIST_W-1:0] r_mem [NUM_NODES*NUM_NODES];

    logic [DIST_W-1:0] r_cell_d    [RES_MAX];
    logic [NODE_W-1:0] r_cell_node [RES_MAX];
    logic [RES_MAX-1:0] r_cell_vld;
    logic [DIST_W-1:0] n_cell_d    [RES_MAX];
    logic [NODE_W-1:0] n_cell_node [RES_MAX];
    logic [RES_MAX-1:0] n_cell_vld;

    logic              accept;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DIST_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic              a_in_grp;
    logic [CNT_W-1:0]  grp_size;
    logic [CNT_W-1:0]  cand;
    logic [NODE_W-1:0] q_n;
    logic              col_in_grp;
    logic              do_insert;
    logic [RES_MAX-1:0] ins;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    // query count: group size less the origin, clipped to the request
    always_comb begin
        if (i_inner_group) begin
            a_in_grp = (i_node_a < r_split);
            grp_size = CNT_W'(r_split);
        end else begin
            a_in_grp = (i_node_a >= r_split);
            grp_size = CNT_W'(NUM_NODES) - CNT_W'(r_split);
        end
        cand = grp_size - CNT_W'(a_in_grp);
        if (CNT_W'(i_wanted_count) > cand) begin
            q_n = cand[NODE_W-1:0];
        end else begin
            q_n = i_wanted_count;
        end
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {i_node_a, i_node_b};
        mem_wdata = i_distance_value[DIST_W-1:0];
        if (accept && i_opcode == OP_WRITE) begin
            mem_we = 1'b1;
        end else if (r_state == ST_WR2) begin
            mem_we    = 1'b1;
            mem_waddr = {r_b, r_a};
            mem_wdata = r_dv;
        end
    end
    assign mem_raddr = {r_a, r_col};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // sorted cell row: insert on scan, shift toward cell 0 on emit
    always_comb begin
        col_in_grp = r_inner ? (r_rd_col < r_split) : (r_rd_col >= r_split);
        do_insert  = r_rd_vld && col_in_grp && (r_rd_col != r_a);
        for (int i = 0; i < RES_MAX; i++) begin
            ins[i] = !r_cell_vld[i] || (r_rd_data < r_cell_d[i]);
        end
        for (int i = 0; i < RES_MAX; i++) begin
            n_cell_d[i]    = r_cell_d[i];
            n_cell_node[i] = r_cell_node[i];
            n_cell_vld[i]  = r_cell_vld[i];
            if (r_state == ST_EMIT) begin
                if (i < RES_MAX - 1) begin
                    n_cell_d[i]    = r_cell_d[i+1];
                    n_cell_node[i] = r_cell_node[i+1];
                    n_cell_vld[i]  = r_cell_vld[i+1];
                end else begin
                    n_cell_vld[i]  = 1'b0;
                end
            end else if (do_insert && ins[i]) begin
                if (i == 0 || !ins[i-1]) begin
                    n_cell_d[i]    = r_rd_data;
                    n_cell_node[i] = r_rd_col;
                    n_cell_vld[i]  = 1'b1;
                end else begin
                    n_cell_d[i]    = r_cell_d[i-1];
                    n_cell_node[i] = r_cell_node[i-1];
                    n_cell_vld[i]  = r_cell_vld[i-1];
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_WRITE) begin
                        n_state = ST_WR2;
                    end else if (q_n != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_WR2:   n_state = ST_IDLE;
            ST_SCAN: begin
                if (r_col == LAST_COL) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_EMIT;
            ST_EMIT: begin
                if (r_k == r_n - NODE_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_split    <= SPLIT_RESET;
            r_rd_vld   <= 1'b0;
            r_cell_vld <= '0;
            o_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN);
            o_strobe <= (r_state == ST_EMIT);
            if (i_cfg_valid && o_cfg_ready) begin
                r_split <= i_cfg_data;
            end
            if (accept) begin
                r_cell_vld <= '0;
            end else begin
                r_cell_vld <= n_cell_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_col <= r_col;
        for (int i = 0; i < RES_MAX; i++) begin
            r_cell_d[i]    <= n_cell_d[i];
            r_cell_node[i] <= n_cell_node[i];
        end
        if (accept) begin
            r_a     <= i_node_a;
            r_b     <= i_node_b;
            r_dv    <= i_distance_value[DIST_W-1:0];
            r_inner <= i_inner_group;
            r_n     <= q_n;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            if (r_state == ST_SCAN) begin
                r_col <= r_col + NODE_W'(1);
            end
            if (r_state == ST_EMIT) begin
                r_k <= r_k + NODE_W'(1);
            end
        end
        o_near_node <= r_cell_node[0];
        o_rank      <= r_k;
        o_last      <= (r_k == r_n - NODE_W'(1));
    end

    `NGMS_ASSERT_NOW(a_emit_valid_cell, r_state == ST_EMIT, r_cell_vld[0], "emit from empty cell")
    `NGMS_ASSERT_NEXT(a_results_contiguous, o_strobe && !o_last, o_strobe, "result gap in query")
    `NGMS_ASSERT_NEXT(a_write_second_entry, accept && i_opcode == OP_WRITE, r_state == ST_WR2, "write missed mirror entry")

endmodule

[tb/sv/nearest_group_member_select_unit_test.sv]
// self-checking testbench for nearest_group_member_select_unit: ranked nearest-node queries
// checked against an in-bench distance table and selector, with random gaps and split changes
// depends on ngms_pkg and the nearest_group_member_select_unit rtl
`timescale 1ns / 1ps

module nearest_group_member_select_unit_test;
    import ngms_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int EXP_DEPTH     = 64;

    localparam logic [NODE_W-1:0] QUERY_ORIGINS [4] = '{5'd0, 5'd3, 5'd5, 5'd31};

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] rank;
        logic              last;
    } ranked_node_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = OP_WRITE;
    logic [NODE_W-1:0] i_node_a = '0;
    logic [NODE_W-1:0] i_node_b = '0;
    logic [15:0]       i_distance_value = '0;
    logic [NODE_W-1:0] i_wanted_count = '0;
    logic              i_inner_group = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [NODE_W-1:0] i_cfg_data = '0;
    logic              o_strobe;
    logic [NODE_W-1:0] o_near_node;
    logic [NODE_W-1:0] o_rank;
    logic              o_last;

    logic [DIST_W-1:0] dist_model [NUM_NODES][NUM_NODES];
    logic [NODE_W-1:0] split_now;
    ranked_node_t      expected_nearest [EXP_DEPTH];
    int                exp_wr = 0;
    int                exp_rd = 0;
    ranked_node_t      head;
    bit                gaps_on = 1'b1;
    int                fail_count = 0;
    int                stall_count = 0;

    nearest_group_member_select_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_node_a        (i_node_a),
        .i_node_b        (i_node_b),
        .i_distance_value(i_distance_value),
        .i_wanted_count  (i_wanted_count),
        .i_inner_group   (i_inner_group),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_near_node     (o_near_node),
        .o_rank          (o_rank),
        .o_last          (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void predict_nearest(input logic [NODE_W-1:0] origin,
                                            input logic [NODE_W-1:0] want,
                                            input logic inner);
        int lo;
        int hi;
        int cand;
        int n;
        int best;
        int j;
        int k;
        logic [DIST_W-1:0] best_d;
        bit found;
        bit [NUM_NODES-1:0] taken;
        ranked_node_t r;
        lo = inner ? 0 : int'(split_now);
        hi = inner ? int'(split_now) : NUM_NODES;
        taken = '0;
        cand = 0;
        for (j = lo; j < hi; j++)
            if (j != origin) cand++;
        n = int'(want);
        if (n > cand) n = cand;
        if (n > RES_MAX) n = RES_MAX;
        for (k = 0; k < n; k++) begin
            found = 1'b0;
            best = 0;
            best_d = '0;
            for (j = lo; j < hi; j++) begin
                if (j == origin || taken[j]) continue;
                if (!found || dist_model[origin][j] < best_d) begin
                    found = 1'b1;
                    best = j;
                    best_d = dist_model[origin][j];
                end
            end
            taken[best] = 1'b1;
            r.node = NODE_W'(best);
            r.rank = NODE_W'(k);
            r.last = (k + 1 == n);
            expected_nearest[exp_wr % EXP_DEPTH] = r;
            exp_wr++;
        end
    endfunction

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] pick_origin();
        return QUERY_ORIGINS[$urandom_range(0, 3)];
    endfunction

    task automatic issue_command(input logic op, input logic [NODE_W-1:0] a,
                                 input logic [NODE_W-1:0] b, input logic [15:0] dist_val,
                                 input logic [NODE_W-1:0] want, input logic inner);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_node_a <= a;
        i_node_b <= b;
        i_distance_value <= dist_val;
        i_wanted_count <= want;
        i_inner_group <= inner;
        do @(posedge i_clk); while (busy);
        if (op == OP_WRITE) begin
            dist_model[a][b] = dist_val[DIST_W-1:0];
            dist_model[b][a] = dist_val[DIST_W-1:0];
        end else begin
            predict_nearest(a, want, inner);
        end
    endtask

    task automatic random_command();
        if ($urandom_range(0, 9) < 4)
            issue_command(OP_WRITE, NODE_W'($urandom), NODE_W'($urandom), pick_distance(),
                          NODE_W'($urandom), 1'($urandom));
        else
            issue_command(OP_QUERY, pick_origin(), NODE_W'($urandom), 16'($urandom),
                          NODE_W'($urandom), 1'($urandom));
    endtask

    task automatic settle_block();
        start <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_split(input logic [NODE_W-1:0] value);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        split_now = value;
    endtask

    // the rows of every query origin get written, bar the origin's own entry, so no query uses an unwritten entry
    task automatic fill_distance_table();
        for (int s = 0; s < 4; s++)
            for (int b = 0; b < NUM_NODES; b++)
                if (NODE_W'(b) != QUERY_ORIGINS[s])
                    issue_command(OP_WRITE, QUERY_ORIGINS[s], NODE_W'(b), pick_distance(),
                                  '0, 1'b0);
    endtask

    task automatic test_directed_queries();
        issue_command(OP_WRITE, 5'd3, 5'd4, 16'd100, 5'd0, 1'b0);
        issue_command(OP_WRITE, 5'd3, 5'd5, 16'd100, 5'd31, 1'b1);
        issue_command(OP_WRITE, 5'd6, 5'd3, 16'd100, 5'd0, 1'b0);
        issue_command(OP_WRITE, 5'd3, 5'd7, 16'h0000, 5'd0, 1'b0);
        issue_command(OP_WRITE, 5'd3, 5'd8, 16'hFFFF, 5'd0, 1'b0);
        issue_command(OP_QUERY, 5'd3, 5'd0, 16'h0000, 5'd31, 1'b1);
        issue_command(OP_QUERY, 5'd3, 5'd31, 16'hFFFF, 5'd0, 1'b1);
        issue_command(OP_QUERY, 5'd3, 5'd0, 16'h0000, 5'd3, 1'b0);
        issue_command(OP_WRITE, 5'd5, 5'd5, 16'hFFFF, 5'd0, 1'b0);
        issue_command(OP_QUERY, 5'd5, 5'd0, 16'h0000, 5'd31, 1'b1);
        issue_command(OP_WRITE, 5'd0, 5'd31, 16'h0000, 5'd0, 1'b0);
        issue_command(OP_WRITE, 5'd31, 5'd30, 16'hFFFF, 5'd0, 1'b0);
        issue_command(OP_QUERY, 5'd0, 5'd0, 16'h0000, 5'd1, 1'b0);
        issue_command(OP_QUERY, 5'd31, 5'd0, 16'h0000, 5'd31, 1'b0);
        issue_command(OP_QUERY, 5'd31, 5'd31, 16'hFFFF, 5'd31, 1'b1);
    endtask

    task automatic test_split_extremes();
        program_split(5'd1);
        issue_command(OP_QUERY, 5'd0, 5'd0, 16'h0000, 5'd5, 1'b1);
        issue_command(OP_QUERY, 5'd9, 5'd0, 16'h0000, 5'd2, 1'b1);
        issue_command(OP_QUERY, 5'd0, 5'd0, 16'h0000, 5'd31, 1'b0);
        program_split(5'd31);
        issue_command(OP_QUERY, 5'd31, 5'd0, 16'h0000, 5'd4, 1'b0);
        issue_command(OP_QUERY, 5'd30, 5'd0, 16'h0000, 5'd4, 1'b0);
        issue_command(OP_QUERY, 5'd31, 5'd0, 16'h0000, 5'd31, 1'b1);
    endtask

    task automatic test_random_traffic(input int count, input logic [NODE_W-1:0] split);
        program_split(split);
        repeat (count) random_command();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (exp_wr == exp_rd) begin
                $error("unexpected result: near_node %0d rank %0d last %0d",
                       o_near_node, o_rank, o_last);
                fail_count++;
            end else begin
                head = expected_nearest[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_near_node !== head.node) begin
                    $error("near_node: expected %0d, actual %0d", head.node, o_near_node);
                    fail_count++;
                end
                if (o_rank !== head.rank) begin
                    $error("rank: expected %0d, actual %0d", head.rank, o_rank);
                    fail_count++;
                end
                if (o_last !== head.last) begin
                    $error("last: expected %0d, actual %0d", head.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // stall counter: any transaction on any channel resets it
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        split_now = SPLIT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fill_distance_table();
        test_directed_queries();
        test_split_extremes();
        test_random_traffic(24, 5'd14);
        test_random_traffic(24, 5'd1);
        test_random_traffic(24, 5'd31);
        test_random_traffic(24, NODE_W'($urandom_range(2, 30)));
        test_random_traffic(24, 5'd20);
        test_random_traffic(24, NODE_W'($urandom_range(2, 30)));
        gaps_on = 1'b0;
        test_random_traffic(24, NODE_W'($urandom_range(1, 31)));
        settle_block();
        if (fail_count == 0 && exp_wr == exp_rd)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/ngms_pkg.sv
design/nearest_group_member_select_unit.sv
tb/sv/nearest_group_member_select_unit_test.sv
